// File: rtl/vmc_pkg.sv
package vmc_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MASK_BITS  = 32;
    localparam int ROW_CAP    = (MAX_ROWS < MASK_BITS) ? MAX_ROWS : MASK_BITS;
    localparam int LEVEL_W    = 16;
    localparam int ROW_W      = 6;
    localparam int PROD_W     = LEVEL_W + ROW_W;
    localparam int QBIT_W     = 3;

    localparam logic [LEVEL_W-1:0] GAIN_DECAY = LEVEL_W'(5);

    localparam logic CFG_NOISE = 1'b0;
    localparam logic CFG_ROWS  = 1'b1;

    localparam logic CMD_GAIN  = 1'b0;
    localparam logic CMD_PAINT = 1'b1;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] level;
        logic [ROW_W-1:0]   rows;
        logic [LEVEL_W-1:0] gain;
    } t_lane_ctl;

    typedef struct packed {
        logic             done;
        logic [ROW_W-1:0] bar;
    } t_lane_sts;

    function automatic logic [MASK_BITS-1:0] column_mask(
        input logic [ROW_W-1:0] bar,
        input logic [ROW_W-1:0] rows
    );
        logic [ROW_W-1:0]     start;
        logic [ROW_W:0]       stop;
        logic [MASK_BITS-1:0] m;
        start = (rows - bar) >> 1;
        stop  = {1'b0, start} + {1'b0, bar};
        for (int y = 0; y < MASK_BITS; y++) begin
            m[y] = ((ROW_W+1)'(y) >= {1'b0, start}) && ((ROW_W+1)'(y) < stop);
        end
        return m;
    endfunction

endpackage

// File: rtl/vu_meter_column_auto_gain_core.sv
// From an input transfer, each lane steps through L_MUL, L_CHK, the six-step
// restoring divider in L_DIV (skipped when the quotient saturates or gain is 0),
// L_FIN and L_DONE, and the output register then loads. A new item is taken only
// after that load, which waits on i_out_ready while the output register is full.
// Reset: synchronous active low; noise level and gain clear to 0, bar rows to 16,
// output register empty.
module vu_meter_column_auto_gain_core
    import vmc_pkg::*;
#(
    parameter int P_MAX_ROWS = MAX_ROWS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [LEVEL_W-1:0]   i_left_level,
    input  logic [LEVEL_W-1:0]   i_right_level,
    input  logic [LEVEL_W-1:0]   i_peak_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MASK_BITS-1:0] o_left_mask,
    output logic [MASK_BITS-1:0] o_right_mask,
    output logic [ROW_W-1:0]     o_left_bar,
    output logic [ROW_W-1:0]     o_right_bar,
    output logic [LEVEL_W-1:0]   o_gain_now
);

    localparam int ROW_LIMIT = (P_MAX_ROWS < MASK_BITS) ? P_MAX_ROWS : MASK_BITS;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state;
    logic [LEVEL_W-1:0] r_noise;
    logic [ROW_W-1:0]   r_bar_rows;
    logic [LEVEL_W-1:0] r_gain;
    logic               r_cmd;
    logic [ROW_W-1:0]   r_rows;

    logic               w_accept;
    logic [LEVEL_W-1:0] w_decayed;
    logic [LEVEL_W-1:0] n_gain;
    logic [ROW_W-1:0]   w_rows;
    logic               w_load;
    logic               w_free;
    t_lane_ctl          w_left_ctl;
    t_lane_ctl          w_right_ctl;
    t_lane_sts          w_left_sts;
    t_lane_sts          w_right_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_decayed = r_gain;
        if (r_gain > r_noise) begin
            w_decayed = (r_gain > GAIN_DECAY) ? (r_gain - GAIN_DECAY) : '0;
        end
        n_gain = (i_peak_level > w_decayed) ? i_peak_level : w_decayed;
    end

    assign w_rows = (r_bar_rows > ROW_W'(ROW_LIMIT)) ? ROW_W'(ROW_LIMIT) : r_bar_rows;

    assign w_left_ctl  = '{start: w_accept, level: i_left_level,  rows: w_rows, gain: r_gain};
    assign w_right_ctl = '{start: w_accept, level: i_right_level, rows: w_rows, gain: r_gain};

    assign w_load = (r_state == S_RUN) && w_left_sts.done && w_right_sts.done && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_noise    <= '0;
            r_bar_rows <= ROW_W'(16);
            r_gain     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NOISE: begin
                        r_noise <= i_cfg_data;
                        r_gain  <= i_cfg_data;
                    end
                    CFG_ROWS: r_bar_rows <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= i_cmd;
                        r_rows <= w_rows;
                        if (i_cmd == CMD_GAIN) begin
                            r_gain <= n_gain;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    vmc_lane u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_left_ctl),
        .o_sts   (w_left_sts)
    );

    vmc_lane u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_right_ctl),
        .o_sts   (w_right_sts)
    );

    vmc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_cmd        (r_cmd),
        .i_rows       (r_rows),
        .i_gain       (r_gain),
        .i_left       (w_left_sts),
        .i_right      (w_right_sts),
        .o_free       (w_free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_left_mask  (o_left_mask),
        .o_right_mask (o_right_mask),
        .o_left_bar   (o_left_bar),
        .o_right_bar  (o_right_bar),
        .o_gain_now   (o_gain_now)
    );

endmodule

// File: rtl/vmc_lane.sv
module vmc_lane
    import vmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    output t_lane_sts o_sts
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_CHK,
        L_DIV,
        L_FIN,
        L_DONE
    } t_lstate;

    t_lstate             r_state;
    logic [LEVEL_W-1:0]  r_level;
    logic [ROW_W-1:0]    r_rows;
    logic [LEVEL_W-1:0]  r_gain;
    logic [PROD_W-1:0]   r_rem;
    logic [ROW_W-1:0]    r_quo;
    logic [QBIT_W-1:0]   r_bit;
    logic [ROW_W-1:0]    r_bar;

    logic [PROD_W-1:0]   w_shifted;
    logic [PROD_W-1:0]   w_full;
    logic [ROW_W-1:0]    w_clamp;
    logic [ROW_W-1:0]    n_bar;

    assign w_shifted = PROD_W'(r_gain) << r_bit;
    assign w_full    = {r_gain, ROW_W'(0)};
    assign w_clamp   = (r_quo > r_rows) ? r_rows : r_quo;

    always_comb begin
        n_bar = w_clamp;
        if (!r_rows[0] && w_clamp[0]) begin
            n_bar = w_clamp + ROW_W'(1);
        end else if (r_rows[0] && (w_clamp > ROW_W'(1)) && !w_clamp[0]) begin
            n_bar = w_clamp - ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            unique case (r_state)
                L_IDLE, L_DONE: begin
                    if (i_ctl.start) begin
                        r_level <= i_ctl.level;
                        r_rows  <= i_ctl.rows;
                        r_gain  <= i_ctl.gain;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_rem   <= PROD_W'(r_level) * PROD_W'(r_rows);
                    r_state <= L_CHK;
                end
                L_CHK: begin
                    if (r_gain == '0) begin
                        r_quo   <= (r_level != '0) ? r_rows : '0;
                        r_state <= L_FIN;
                    end else if (r_rem >= w_full) begin
                        r_quo   <= '1;
                        r_state <= L_FIN;
                    end else begin
                        r_quo   <= '0;
                        r_bit   <= QBIT_W'(ROW_W - 1);
                        r_state <= L_DIV;
                    end
                end
                L_DIV: begin
                    if (r_rem >= w_shifted) begin
                        r_rem        <= r_rem - w_shifted;
                        r_quo[r_bit] <= 1'b1;
                    end
                    if (r_bit == '0) begin
                        r_state <= L_FIN;
                    end else begin
                        r_bit <= r_bit - QBIT_W'(1);
                    end
                end
                L_FIN: begin
                    r_bar   <= n_bar;
                    r_state <= L_DONE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_sts.done = (r_state == L_DONE);
    assign o_sts.bar  = r_bar;

endmodule

// File: rtl/vmc_merge.sv
module vmc_merge
    import vmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_cmd,
    input  logic [ROW_W-1:0]     i_rows,
    input  logic [LEVEL_W-1:0]   i_gain,
    input  t_lane_sts            i_left,
    input  t_lane_sts            i_right,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MASK_BITS-1:0] o_left_mask,
    output logic [MASK_BITS-1:0] o_right_mask,
    output logic [ROW_W-1:0]     o_left_bar,
    output logic [ROW_W-1:0]     o_right_bar,
    output logic [LEVEL_W-1:0]   o_gain_now
);

    logic                 r_valid;
    logic [MASK_BITS-1:0] r_left_mask;
    logic [MASK_BITS-1:0] r_right_mask;
    logic [ROW_W-1:0]     r_left_bar;
    logic [ROW_W-1:0]     r_right_bar;
    logic [LEVEL_W-1:0]   r_gain_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gain_now <= i_gain;
            if (i_cmd == CMD_PAINT) begin
                r_left_mask  <= column_mask(i_left.bar, i_rows);
                r_right_mask <= column_mask(i_right.bar, i_rows);
                r_left_bar   <= i_left.bar;
                r_right_bar  <= i_right.bar;
            end else begin
                r_left_mask  <= '0;
                r_right_mask <= '0;
                r_left_bar   <= '0;
                r_right_bar  <= '0;
            end
        end
    end

    assign o_free       = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_left_mask  = r_left_mask;
    assign o_right_mask = r_right_mask;
    assign o_left_bar   = r_left_bar;
    assign o_right_bar  = r_right_bar;
    assign o_gain_now   = r_gain_now;

endmodule

// File: rtl/vmc_checker.sv
module vmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_left_mask,
    input logic [31:0] o_right_mask,
    input logic [5:0]  o_left_bar,
    input logic [5:0]  o_right_bar,
    input logic [15:0] o_gain_now
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_mask)
            && $stable(o_right_mask) && $stable(o_gain_now))
        else $error("stalled output changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after transfer");

    a_mask_matches_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_left_mask) == 32'(o_left_bar))
            && ($countones(o_right_mask) == 32'(o_right_bar)))
        else $error("mask does not match bar height");

endmodule

bind vu_meter_column_auto_gain_core vmc_checker u_vmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_left_mask  (o_left_mask),
    .o_right_mask (o_right_mask),
    .o_left_bar   (o_left_bar),
    .o_right_bar  (o_right_bar),
    .o_gain_now   (o_gain_now)
);
